@@ rtl/pelb_pkg.sv @@
package pelb_pkg;

  localparam int unsigned MaxRowPixels   = 1024;
  localparam int unsigned PaletteEntries = 256;

  localparam int unsigned PixW     = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned ColorW   = 32;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned ColW   = $clog2(MaxRowPixels + 1);
  localparam int unsigned LineAw = $clog2(MaxRowPixels);
  localparam int unsigned PalAw  = $clog2(PaletteEntries);

  typedef enum logic [CfgIdxW-1:0] {
    RegBlendEnable = 2'd0,
    RegOutputDepth = 2'd1,
    RegBorderPixel = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    Depth8  = 2'd0,
    Depth16 = 2'd1,
    Depth24 = 2'd2,
    Depth32 = 2'd3
  } depth_e;

  function automatic logic [ColorW-1:0] depth_mask(depth_e d);
    logic [ColorW-1:0] m;
    case (d)
      Depth8:  m = 32'h0000_00FF;
      Depth16: m = 32'h0000_FFFF;
      Depth24: m = 32'h00FF_FFFF;
      Depth32: m = 32'hFFFF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/palette_expand_line_blend_unit.sv @@
// A rendered pixel's color is offered in the cycle after its word is accepted.
// Throughput: one word per cycle unless the output stalls, palette writes and pixels
// alike; palette, line store: single-port RAMs, one access per word, registered reads.
// Reset (rst_ni, async, active low): config to blend off, 32-bit depth, border zero;
// column zero, first row set, output empty. The line store reads as zero until written
// (tracked by a fill count, no clearing pass); the palette is undefined until written.
module palette_expand_line_blend_unit
  import pelb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                frame_start_i,
  input  logic                row_end_i,
  input  logic [PixW-1:0]     palette_index_i,
  input  logic [ColorW-1:0]   palette_value_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ColorW-1:0]   color_o,
  output logic                row_last_o
);

  logic                blend_q;
  depth_e              depth_q;
  logic [NibW-1:0]     border_q;

  logic                out_valid_q, out_valid_d;
  logic [ColW-1:0]     column_q, column_d;
  logic                first_row_q, first_row_d;
  logic [ColW-1:0]     fill_q, fill_d;
  logic                al_mem_q, al_mem_d;
  logic [NibW-1:0]     al_fix_q, al_fix_d;

  logic [NibW-1:0]     line_mem [MaxRowPixels];
  logic [NibW-1:0]     line_rd_q;
  logic [ColorW-1:0]   pal_mem [PaletteEntries];
  logic [ColorW-1:0]   pal_rd_q;
  logic                pal_oob_q;
  logic                row_last_q;

  logic                in_ready, render_acc, write_acc;
  logic [ColW-1:0]     col_eff;
  logic                first_eff, in_store;
  logic [NibW-1:0]     above_left, neighbor;
  logic [PixW-1:0]     pal_idx;
  logic                rd_in_range, wr_in_range;

  assign in_ready   = !out_valid_q || out_ready_i;
  assign render_acc = in_valid_i && in_ready && action_i;
  assign write_acc  = in_valid_i && in_ready && !action_i;

  always_comb begin
    col_eff     = frame_start_i ? '0 : column_q;
    first_eff   = frame_start_i || first_row_q;
    in_store    = col_eff < ColW'(MaxRowPixels);
    above_left  = al_mem_q ? line_rd_q : al_fix_q;
    neighbor    = (first_eff || col_eff == '0) ? border_q : above_left;
    pal_idx     = blend_q ? {pixel_i[PixW-1:NibW] | neighbor, pixel_i[NibW-1:0]} : pixel_i;
    rd_in_range = {1'b0, pal_idx} < (PixW + 1)'(PaletteEntries);
    wr_in_range = {1'b0, palette_index_i} < (PixW + 1)'(PaletteEntries);

    out_valid_d = out_valid_q;
    column_d    = column_q;
    first_row_d = first_row_q;
    fill_d      = fill_q;
    al_mem_d    = al_mem_q;
    al_fix_d    = al_fix_q;

    if (in_ready) begin
      out_valid_d = render_acc;
    end

    if (render_acc) begin
      // written entries always form a prefix of the line store
      if (in_store) begin
        al_mem_d = col_eff < fill_q;
        al_fix_d = '0;
        if (col_eff >= fill_q) begin
          fill_d = col_eff + ColW'(1);
        end
      end else begin
        al_mem_d = 1'b0;
        al_fix_d = border_q;
      end

      if (row_end_i) begin
        column_d    = '0;
        first_row_d = 1'b0;
      end else begin
        column_d    = in_store ? col_eff + ColW'(1) : col_eff;
        first_row_d = first_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q     <= 1'b0;
      depth_q     <= Depth32;
      border_q    <= '0;
      out_valid_q <= 1'b0;
      column_q    <= '0;
      first_row_q <= 1'b1;
      fill_q      <= '0;
      al_mem_q    <= 1'b0;
      al_fix_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegBlendEnable: blend_q  <= cfg_data_i[0];
          RegOutputDepth: depth_q  <= depth_e'(cfg_data_i[1:0]);
          RegBorderPixel: border_q <= cfg_data_i[NibW-1:0];
          default: ;
        endcase
      end
      out_valid_q <= out_valid_d;
      column_q    <= column_d;
      first_row_q <= first_row_d;
      fill_q      <= fill_d;
      al_mem_q    <= al_mem_d;
      al_fix_q    <= al_fix_d;
    end
  end

  // line store: read-before-write at the current column
  always_ff @(posedge clk_i) begin
    if (render_acc && in_store) begin
      line_rd_q                      <= line_mem[col_eff[LineAw-1:0]];
      line_mem[col_eff[LineAw-1:0]] <= pixel_i[NibW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_acc && wr_in_range) begin
      pal_mem[palette_index_i[PalAw-1:0]] <= palette_value_i;
    end
    if (render_acc) begin
      pal_rd_q   <= pal_mem[pal_idx[PalAw-1:0]];
      pal_oob_q  <= !rd_in_range;
      row_last_q <= row_end_i;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign color_o     = pal_oob_q ? '0 : (pal_rd_q & depth_mask(depth_q));
  assign row_last_o  = row_last_q;

  a_col_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    column_q <= fill_q)
    else $error("column beyond line store fill count");

  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= ColW'(MaxRowPixels))
    else $error("fill count beyond line store depth");

  a_render_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_acc |=> out_valid_q)
    else $error("accepted pixel produced no output word");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_acc && row_end_i |=> column_q == '0 && !first_row_q)
    else $error("row end did not rewind column");

  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_acc |=> !out_valid_q)
    else $error("palette write produced an output word");

endmodule

@@ test/palette_expand_line_blend_checker.sv @@
`timescale 1ns / 1ps

module palette_expand_line_blend_checker
  import pelb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,

  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                action_i,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                frame_start_i,
  input  logic                row_end_i,
  input  logic [PixW-1:0]     palette_index_i,
  input  logic [ColorW-1:0]   palette_value_i,

  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [ColorW-1:0]   color_i,
  input  logic                row_last_i,

  output int                  pending_o,
  output int                  errors_o
);

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic              row_last;
  } color_word_t;

  logic [ColorW-1:0] palette_words [PaletteEntries];
  logic [NibW-1:0]   line_nibbles  [MaxRowPixels];
  logic [ColW-1:0]   column;
  logic              first_row;
  logic [NibW-1:0]   above_left;

  logic              blend_on;
  depth_e            depth_kept;
  logic [NibW-1:0]   border;

  color_word_t       colors_due [$];
  int                fails = 0;

  assign errors_o = fails;

  function void render_pixel(logic [PixW-1:0] pix, logic fs, logic re);
    logic [NibW-1:0]   neighbor;
    logic [PixW-1:0]   idx;
    logic [ColorW-1:0] mask;
    color_word_t       w;
    if (fs) begin
      column    = '0;
      first_row = 1'b1;
    end
    neighbor = (first_row || column == 0) ? border : above_left;
    if (column < MaxRowPixels) begin
      above_left = line_nibbles[column[LineAw-1:0]];
      line_nibbles[column[LineAw-1:0]] = pix[NibW-1:0];
    end else begin
      above_left = border;
    end
    idx  = blend_on ? {pix[7:4] | neighbor, pix[3:0]} : pix;
    mask = 32'hFFFF_FFFF >> (8 * (3 - int'(depth_kept)));
    w.color    = palette_words[idx] & mask;
    w.row_last = re;
    colors_due.push_back(w);
    if (re) begin
      column    = '0;
      first_row = 1'b0;
    end else if (column < MaxRowPixels) begin
      column = column + 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    color_word_t w;
    if (!rst_ni) begin
      blend_on   = 1'b0;
      depth_kept = Depth32;
      border     = '0;
      column     = '0;
      first_row  = 1'b1;
      above_left = '0;
      foreach (line_nibbles[i]) line_nibbles[i] = '0;
      colors_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegBlendEnable: blend_on   = cfg_data_i[0];
          RegOutputDepth: depth_kept = depth_e'(cfg_data_i[1:0]);
          RegBorderPixel: border     = cfg_data_i[NibW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (colors_due.size() == 0) begin
          $error("unexpected word: color %h row_last %b", color_i, row_last_i);
          fails++;
        end else begin
          w = colors_due.pop_front();
          if (color_i !== w.color) begin
            $error("color: expected %h, got %h", w.color, color_i);
            fails++;
          end
          if (row_last_i !== w.row_last) begin
            $error("row_last: expected %b, got %b", w.row_last, row_last_i);
            fails++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        if (action_i) render_pixel(pixel_i, frame_start_i, row_end_i);
        else palette_words[palette_index_i] = palette_value_i;
      end

      pending_o <= colors_due.size();
    end
  end

endmodule

@@ test/palette_expand_line_blend_unit_tb.sv @@
`timescale 1ns / 1ps

module palette_expand_line_blend_unit_tb
  import pelb_pkg::*;
;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;

  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                action_i = 1'b0;
  logic [PixW-1:0]     pixel_i = '0;
  logic                frame_start_i = 1'b0;
  logic                row_end_i = 1'b0;
  logic [PixW-1:0]     palette_index_i = '0;
  logic [ColorW-1:0]   palette_value_i = '0;

  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [ColorW-1:0]   color_o;
  logic                row_last_o;

  int pending;
  int errors;

  int words_sent = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_reqs = 0;
  int holds_done = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  palette_expand_line_blend_unit dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .action_i, .pixel_i, .frame_start_i, .row_end_i, .palette_index_i, .palette_value_i,
    .out_valid_o, .out_ready_i, .color_o, .row_last_o
  );

  palette_expand_line_blend_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .action_i, .pixel_i, .frame_start_i, .row_end_i, .palette_index_i, .palette_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .color_i(color_o), .row_last_i(row_last_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: ready follows one of four randomly drawn modes, long hold on request
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        cyc++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (cyc % 4 != 0);
        endcase
      end
    end
  end

  task automatic push_word(input logic act, input logic [PixW-1:0] pix, input logic fs,
                           input logic re, input logic [PixW-1:0] pidx,
                           input logic [ColorW-1:0] pval);
    int gap;
    in_valid_i      <= 1'b1;
    action_i        <= act;
    pixel_i         <= pix;
    frame_start_i   <= fs;
    row_end_i       <= re;
    palette_index_i <= pidx;
    palette_value_i <= pval;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (no_gaps) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic pixel(input logic [PixW-1:0] pix, input logic fs, input logic re);
    push_word(1'b1, pix, fs, re, PixW'($urandom), $urandom);
  endtask

  task automatic palette_write(input logic [PixW-1:0] pidx, input logic [ColorW-1:0] pval);
    push_word(1'b0, PixW'($urandom), 1'($urandom), 1'($urandom), pidx, pval);
  endtask

  // drain, then leave room for a trailing palette write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic blend, input depth_e depth, input logic [NibW-1:0] brd);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegBlendEnable;
    cfg_data_i  <= {3'b000, blend};
    @(posedge clk_i);
    cfg_index_i <= RegOutputDepth;
    cfg_data_i  <= {2'b00, depth};
    @(posedge clk_i);
    cfg_index_i <= RegBorderPixel;
    cfg_data_i  <= brd;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_rows(input int budget);
    int left;
    int row_len;
    logic fs;
    left = budget;
    fs   = 1'($urandom_range(0, 1));
    while (left > 0) begin
      row_len = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      for (int i = 0; i < row_len && left > 0; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          palette_write(PixW'($urandom), $urandom);
          left--;
        end
        pixel(PixW'($urandom), fs || ($urandom_range(0, 60) == 0), i == row_len - 1);
        fs = 1'b0;
        left--;
      end
    end
  endtask

  // one row past the line store, then a short row that reads it back
  task automatic long_rows();
    for (int i = 0; i < 1030; i++) pixel(PixW'($urandom), i == 0, i == 1029);
    for (int i = 0; i < 8; i++) pixel(PixW'($urandom), 1'b0, i == 7);
  endtask

  task automatic flood_while_held();
    hold_reqs <= hold_reqs + 1;
    no_gaps = 1'b1;
    for (int i = 0; i < 48; i++) pixel(PixW'($urandom), 1'b0, i % 12 == 11);
    no_gaps = 1'b0;
  endtask

  initial begin
    int k;
    int guard;
    logic blend;
    depth_e depth;
    logic [NibW-1:0] brd;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(1'b0, Depth32, 4'h0);
    for (int i = 0; i < PaletteEntries; i++) begin
      palette_write(PixW'(i), (i == 0) ? 32'h0 : (i == 255) ? 32'hFFFF_FFFF : $urandom);
    end

    wait_idle();
    set_config(1'b1, Depth32, 4'hF);
    palette_write(8'h00, 32'hFFFF_FFFF);
    pixel(8'hFF, 1'b1, 1'b1);
    pixel(8'h00, 1'b1, 1'b0);
    pixel(8'hFF, 1'b0, 1'b0);
    pixel(8'h5A, 1'b0, 1'b0);
    pixel(8'hA5, 1'b0, 1'b1);
    pixel(8'h0F, 1'b0, 1'b0);
    pixel(8'hF0, 1'b0, 1'b0);
    pixel(8'h33, 1'b0, 1'b0);
    pixel(8'hCC, 1'b0, 1'b1);
    pixel(8'h12, 1'b0, 1'b0);
    pixel(8'h34, 1'b1, 1'b0);
    pixel(8'h56, 1'b0, 1'b1);
    pixel(8'h77, 1'b0, 1'b0);
    pixel(8'h88, 1'b0, 1'b1);
    palette_write(8'hFF, 32'h0000_0000);
    pixel(8'hFF, 1'b0, 1'b1);
    wait_idle();
    set_config(1'b0, Depth8, 4'h5);
    pixel(8'h00, 1'b1, 1'b0);
    pixel(8'h80, 1'b0, 1'b0);
    pixel(8'hFF, 1'b0, 1'b1);

    k = 0;
    while (words_sent < 1450) begin
      wait_idle();
      blend = (k < 4) ? (k == 1 || k == 2) : 1'($urandom_range(0, 1));
      depth = (k < 4) ? depth_e'(k) : depth_e'($urandom_range(0, 3));
      brd   = (k == 0) ? 4'h0 : (k == 1) ? 4'hF : NibW'($urandom);
      set_config(blend, depth, brd);
      if (k == 2) long_rows();
      else if (k == 1) flood_while_held();
      else random_rows($urandom_range(40, 140));
      k++;
    end

    in_valid_i <= 1'b0;
    for (guard = 0; guard < 5000 && pending != 0; guard++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending != 0) $error("%0d colors never came out", pending);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
